@@ rtl/affine_quantize_float_to_int_assert.svh @@
// Assertion macros for the affine quantizer.
// Used at the end of the top level; expects clk and rst_n in scope.
`ifndef AFFINE_QUANTIZE_FLOAT_TO_INT_ASSERT_SVH
`define AFFINE_QUANTIZE_FLOAT_TO_INT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define AQF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AQF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aqf_pkg.sv @@
// Shared types and constants for the affine quantizer.
// No dependencies; imported by every module of the block.
package aqf_pkg;

    localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

    localparam logic [1:0] CFG_INV_SCALE = 2'd0;
    localparam logic [1:0] CFG_ZERO_OFF  = 2'd1;
    localparam logic [1:0] CFG_TYPE      = 2'd2;

    localparam logic [1:0] TYPE_INT8  = 2'd0;
    localparam logic [1:0] TYPE_UINT8 = 2'd1;
    localparam logic [1:0] TYPE_INT32 = 2'd2;

    // Normalized operands, exponent of the product's unit position.
    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic [23:0]        man_a;
        logic [23:0]        man_b;
        logic signed [10:0] exp_sum;
        logic               last;
    } aqf_norm_t;

    typedef struct packed {
        logic               sign;
        logic               nan;
        logic               inf;
        logic               zero;
        logic [47:0]        prod;
        logic signed [10:0] exp_sum;
        logic               last;
    } aqf_prod_t;

    typedef struct packed {
        logic        sign;
        logic        sat;
        logic [40:0] mag;
        logic        last;
    } aqf_mag_t;

endpackage

@@ rtl/aqf_unpack.sv @@
// Operand unpack: classify both float32 operands and normalize subnormals.
// Depends on aqf_pkg.
module aqf_unpack (
    input  logic [31:0]       sample_bits,
    input  logic [31:0]       scale_bits,
    input  logic              last,
    output aqf_pkg::aqf_norm_t norm
);
    import aqf_pkg::*;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        begin
            n = 5'd24;
            found = 1'b0;
            for (int i = 23; i >= 0; i--) begin
                if (!found && v[i]) begin
                    n = 5'(23 - i);
                    found = 1'b1;
                end
            end
            return n;
        end
    endfunction

    logic [7:0]         ex_a, ex_b;
    logic [23:0]        full_a, full_b;
    logic [4:0]         lz_a, lz_b;
    logic signed [10:0] texp_a, texp_b;
    logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

    assign ex_a = sample_bits[30:23];
    assign ex_b = scale_bits[30:23];
    assign full_a = {ex_a != 8'd0, sample_bits[22:0]};
    assign full_b = {ex_b != 8'd0, scale_bits[22:0]};

    assign nan_a  = (ex_a == 8'hFF) && (sample_bits[22:0] != 23'd0);
    assign nan_b  = (ex_b == 8'hFF) && (scale_bits[22:0] != 23'd0);
    assign inf_a  = (ex_a == 8'hFF) && (sample_bits[22:0] == 23'd0);
    assign inf_b  = (ex_b == 8'hFF) && (scale_bits[22:0] == 23'd0);
    assign zero_a = (ex_a == 8'd0) && (sample_bits[22:0] == 23'd0);
    assign zero_b = (ex_b == 8'd0) && (scale_bits[22:0] == 23'd0);

    assign lz_a = lzc24(full_a);
    assign lz_b = lzc24(full_b);

    // Unbiased exponent of the leading mantissa bit after normalization.
    assign texp_a = $signed({3'b000, (ex_a == 8'd0) ? 8'd1 : ex_a}) - 11'sd127
                    - $signed({6'b000000, lz_a});
    assign texp_b = $signed({3'b000, (ex_b == 8'd0) ? 8'd1 : ex_b}) - 11'sd127
                    - $signed({6'b000000, lz_b});

    always_comb
    begin
        norm.sign    = sample_bits[31] ^ scale_bits[31];
        norm.nan     = nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a);
        norm.inf     = !norm.nan && (inf_a || inf_b);
        norm.zero    = !norm.nan && !norm.inf && (zero_a || zero_b);
        norm.man_a   = full_a << lz_a;
        norm.man_b   = full_b << lz_b;
        norm.exp_sum = texp_a + texp_b;
        norm.last    = last;
    end

endmodule

@@ rtl/aqf_mul.sv @@
// Significand multiplier: 24 x 24 bit product of normalized mantissas.
// Depends on aqf_pkg.
module aqf_mul (
    input  aqf_pkg::aqf_norm_t norm,
    output aqf_pkg::aqf_prod_t prod
);
    import aqf_pkg::*;

    always_comb
    begin
        prod.sign    = norm.sign;
        prod.nan     = norm.nan;
        prod.inf     = norm.inf;
        prod.zero    = norm.zero;
        prod.prod    = {24'd0, norm.man_a} * {24'd0, norm.man_b};
        prod.exp_sum = norm.exp_sum;
        prod.last    = norm.last;
    end

endmodule

@@ rtl/aqf_round.sv @@
// Round the product to float32 (nearest even), then to an integer magnitude
// (nearest even), flagging saturation at 2^40 and above. Depends on aqf_pkg.
module aqf_round (
    input  aqf_pkg::aqf_prod_t prod,
    output aqf_pkg::aqf_mag_t  mag
);
    import aqf_pkg::*;

    logic [23:0]        frac;
    logic               rnd, sticky, inc;
    logic signed [11:0] e_res, e_rnd, d_left, d_right;
    logic [24:0]        frac_rnd;
    logic [23:0]        frac_n;
    logic [47:0]        ext;
    logic [23:0]        ip;
    logic               inc_int;

    always_comb
    begin
        if (prod.prod[47])
        begin
            frac   = prod.prod[47:24];
            rnd    = prod.prod[23];
            sticky = |prod.prod[22:0];
        end
        else
        begin
            frac   = prod.prod[46:23];
            rnd    = prod.prod[22];
            sticky = |prod.prod[21:0];
        end
        // Product value is prod * 2^(exp_sum - 46); leading bit weight below.
        e_res    = 12'(prod.exp_sum) + {11'd0, prod.prod[47]};
        inc      = rnd && (sticky || frac[0]);
        frac_rnd = {1'b0, frac} + {24'd0, inc};
        frac_n   = frac_rnd[24] ? 24'h80_0000 : frac_rnd[23:0];
        e_rnd    = frac_rnd[24] ? e_res + 12'sd1 : e_res;
        d_left   = e_rnd - 12'sd23;
        d_right  = 12'sd23 - e_rnd;

        ext      = {frac_n, 24'd0} >> d_right[4:0];
        ip       = ext[47:24];
        inc_int  = ext[23] && ((|ext[22:0]) || ip[0]);

        mag.sign = prod.sign;
        mag.last = prod.last;
        mag.sat  = 1'b0;
        mag.mag  = 41'd0;
        if (prod.nan || prod.zero)
        begin
            mag.mag = 41'd0;
        end
        else if (prod.inf || e_res >= 12'sd40 || e_rnd >= 12'sd40)
        begin
            mag.sat = 1'b1;
        end
        else if (e_res <= -12'sd2)
        begin
            mag.mag = 41'd0;
        end
        else if (e_rnd >= 12'sd23)
        begin
            mag.mag = {17'd0, frac_n} << d_left[4:0];
        end
        else
        begin
            mag.mag = {17'd0, ip} + {40'd0, inc_int};
        end
    end

endmodule

@@ rtl/aqf_clamp.sv @@
// Add the integer zero point and clamp to the selected output type.
// Depends on aqf_pkg.
module aqf_clamp (
    input  aqf_pkg::aqf_mag_t mag,
    input  logic [31:0]       zero_offset,
    input  logic [1:0]        target_type,
    output logic [31:0]       quantized,
    output logic              offset_invalid
);
    import aqf_pkg::*;

    logic signed [41:0] lo, hi, zp, val, sum, res;

    always_comb
    begin
        case (target_type)
            TYPE_INT8:
            begin
                lo = -42'sd128;
                hi = 42'sd127;
            end
            TYPE_UINT8:
            begin
                lo = 42'sd0;
                hi = 42'sd255;
            end
            default:
            begin
                lo = -42'sd2147483648;
                hi = 42'sd2147483647;
            end
        endcase
        zp  = 42'(signed'(zero_offset));
        val = mag.sign ? -$signed({1'b0, mag.mag}) : $signed({1'b0, mag.mag});
        sum = val + zp;
        if (mag.sat)
            res = mag.sign ? lo : hi;
        else if (sum < lo)
            res = lo;
        else if (sum > hi)
            res = hi;
        else
            res = sum;
        quantized      = res[31:0];
        offset_invalid = (zp < lo) || (zp > hi);
    end

endmodule

@@ rtl/affine_quantize_float_to_int.sv @@
// Affine quantizer top level: float32 samples to int8 / uint8 / int32.
// Depends on aqf_pkg, aqf_unpack, aqf_mul, aqf_round, aqf_clamp and the
// assertion header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries sample_bits, a float32 bit
//   pattern, and last_in. Output channel (out_valid/out_ready) returns
//   quantized, offset_invalid and last_out, one result per request.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   inverse_scale (0), zero_offset (1) and target_type (2); cfg_ready is
//   always high. Write config only while the pipe is empty.
//   A request accepted at the input passes through the input, normalize,
//   multiply, round and clamp registers in turn before it reaches the output.
//   Throughput: one request per cycle while out_ready stays high; every
//   stage advances whenever the stage after it has room.
//   When the receiver stalls, the pipe fills and in_ready drops once all
//   five registers hold requests; nothing is dropped.
//   Reset empties the pipe and loads inverse_scale = 1.0, zero_offset = 0,
//   target_type = int8.
module affine_quantize_float_to_int (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] sample_bits,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [31:0] quantized,
    output logic        offset_invalid,
    output logic        last_out,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import aqf_pkg::*;

    logic [31:0] recip_scale_reg, zero_off_reg;
    logic [1:0]  type_reg;

    logic [31:0] s0_bits_reg;
    logic        s0_last_reg;
    aqf_norm_t   s1_reg, s1_next;
    aqf_prod_t   s2_reg, s2_next;
    aqf_mag_t    s3_reg, s3_next;
    logic [31:0] q_reg, q_next;
    logic        inv_reg, inv_next, last_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic en0, en1, en2, en3, en4;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recip_scale_reg <= SCALE_RESET;
            zero_off_reg    <= 32'd0;
            type_reg        <= TYPE_INT8;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INV_SCALE: recip_scale_reg <= cfg_data;
                CFG_ZERO_OFF:  zero_off_reg    <= cfg_data;
                CFG_TYPE:      type_reg        <= cfg_data[1:0];
                default:       ;
            endcase
        end
    end

    // Advance a stage when it is empty or its successor advances.
    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign in_ready = en0;

    aqf_unpack u_unpack (
        .sample_bits (s0_bits_reg),
        .scale_bits  (recip_scale_reg),
        .last        (s0_last_reg),
        .norm        (s1_next)
    );

    aqf_mul u_mul (
        .norm (s1_reg),
        .prod (s2_next)
    );

    aqf_round u_round (
        .prod (s2_reg),
        .mag  (s3_next)
    );

    aqf_clamp u_clamp (
        .mag            (s3_reg),
        .zero_offset    (zero_off_reg),
        .target_type    (type_reg),
        .quantized      (q_next),
        .offset_invalid (inv_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= in_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            s0_bits_reg <= sample_bits;
            s0_last_reg <= last_in;
        end
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4)
        begin
            q_reg    <= q_next;
            inv_reg  <= inv_next;
            last_reg <= s3_reg.last;
        end
    end

    assign out_valid      = v4_reg;
    assign quantized      = q_reg;
    assign offset_invalid = inv_reg;
    assign last_out       = last_reg;

`include "affine_quantize_float_to_int_assert.svh"

    `AQF_ASSERT_NOW(a_int8_range, out_valid && type_reg == TYPE_INT8, quantized >= -32'sd128 && quantized <= 32'sd127, "int8 result out of range")
    `AQF_ASSERT_NOW(a_uint8_range, out_valid && type_reg == TYPE_UINT8, quantized >= 32'sd0 && quantized <= 32'sd255, "uint8 result out of range")
    `AQF_ASSERT_NOW(a_stall_full, v0_reg && v1_reg && v2_reg && v3_reg && v4_reg && !out_ready, !in_ready, "pipe accepted a request while full and stalled")

endmodule

@@ tb/affine_quantize_float_to_int_tb.sv @@
// Self-checking testbench for the affine float32-to-integer quantizer.
// Drives samples and register writes under random gaps and output stalls; needs aqf_pkg
// and the top level only. Expected values come from a bit-exact float predictor.
`timescale 1ns / 1ps

module affine_quantize_float_to_int_tb;
    import aqf_pkg::*;

    localparam longint BIG_MAG = 64'sd1 << 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] value;
        logic               bad_offset;
        logic               last;
    } quant_result_t;

    class quant_scoreboard;
        logic [31:0]   recip_scale;
        logic [31:0]   zero_pt;
        logic [1:0]    out_type;
        quant_result_t pending_q[$];
        int            errors;
        int            checked;

        function new();
            recip_scale = SCALE_RESET;
            zero_pt     = '0;
            out_type    = TYPE_INT8;
            errors      = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == CFG_INV_SCALE)
                recip_scale = data;
            else if (idx == CFG_ZERO_OFF)
                zero_pt = data;
            else if (idx == CFG_TYPE)
                out_type = data[1:0];
        endfunction

        // Exact widening of a finite float32 pattern to a double.
        function real widen(logic [31:0] b);
            logic [63:0] d;
            int          p;
            d = '0;
            d[63] = b[31];
            if (b[30:23] != 0) begin
                d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
                d[51:29] = b[22:0];
            end else if (b[22:0] != 0) begin
                p = 0;
                for (int i = 0; i < 23; i++)
                    if (b[i]) p = i;
                d[62:52] = 11'(p - 149 + 1023);
                d[51:0]  = 52'((64'(b[22:0]) << (52 - p)));
            end
            return $bitstoreal(d);
        endfunction

        // Round a nonzero finite double to float32 bits, nearest-even.
        function logic [31:0] narrow(real r);
            logic [63:0] db, m, ip, rem, half;
            int          e, sh;
            db = $realtobits(r);
            if (db[62:0] == 0)
                return {db[63], 31'b0};
            e  = int'(db[62:52]) - 1023;
            m  = {11'b0, 1'b1, db[51:0]};
            sh = (e < -126) ? 29 + (-126 - e) : 29;
            if (sh > 60) begin
                ip = 0;
            end else begin
                ip   = m >> sh;
                rem  = m & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (rem > half || (rem == half && ip[0]))
                    ip++;
            end
            if (e >= -126) begin
                if (ip == (64'd1 << 24)) begin
                    ip = ip >> 1;
                    e++;
                end
                if (e > 127)
                    return {db[63], 8'hFF, 23'b0};
                return {db[63], 8'(e + 127), ip[22:0]};
            end
            return {db[63], ip[30:0]};
        endfunction

        // Integer nearest-even of a float32; NaN gives zero, huge clips to 2^40.
        function longint to_integer(logic [31:0] b);
            logic [31:0] man, ip, rem, half;
            int          ex, sh, k;
            longint      mag;
            ex  = int'(b[30:23]);
            man = {9'b0, b[22:0]};
            if (ex == 255) begin
                if (man != 0) return 0;
                mag = BIG_MAG;
            end else begin
                if (ex != 0) man[23] = 1'b1;
                else ex = 1;
                sh = ex - 150;
                if (sh >= 0) begin
                    mag = (sh > 16) ? BIG_MAG : longint'(man) << sh;
                end else begin
                    k = -sh;
                    if (k >= 32) begin
                        mag = 0;
                    end else begin
                        ip   = man >> k;
                        rem  = man & ((32'd1 << k) - 1);
                        half = 32'd1 << (k - 1);
                        if (rem > half || (rem == half && ip[0]))
                            ip++;
                        mag = longint'(ip);
                    end
                end
            end
            return b[31] ? -mag : mag;
        endfunction

        function void note_request(logic [31:0] sample, logic last);
            quant_result_t r;
            logic [31:0]   prod;
            logic          x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
            longint        zp, q, lo, hi;
            x_nan  = sample[30:23] == 8'hFF && sample[22:0] != 0;
            s_nan  = recip_scale[30:23] == 8'hFF && recip_scale[22:0] != 0;
            x_inf  = sample[30:23] == 8'hFF && sample[22:0] == 0;
            s_inf  = recip_scale[30:23] == 8'hFF && recip_scale[22:0] == 0;
            x_zero = sample[30:0] == 0;
            s_zero = recip_scale[30:0] == 0;
            if (x_nan || s_nan || (x_inf && s_zero) || (s_inf && x_zero))
                prod = 32'h7FC0_0000;
            else if (x_inf || s_inf)
                prod = {sample[31] ^ recip_scale[31], 8'hFF, 23'b0};
            else if (x_zero || s_zero)
                prod = {sample[31] ^ recip_scale[31], 31'b0};
            else
                prod = narrow(widen(sample) * widen(recip_scale));
            zp = longint'(signed'(zero_pt));
            if (out_type == TYPE_INT8) begin
                lo = -128; hi = 127;
            end else if (out_type == TYPE_UINT8) begin
                lo = 0; hi = 255;
            end else begin
                lo = -(64'sd1 << 31); hi = (64'sd1 << 31) - 1;
            end
            q = to_integer(prod);
            if (q >= BIG_MAG) q = hi;
            else if (q <= -BIG_MAG) q = lo;
            else q = q + zp;
            if (q < lo) q = lo;
            if (q > hi) q = hi;
            r.value      = 32'(q);
            r.bad_offset = zp < lo || zp > hi;
            r.last       = last;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [31:0] value, logic bad, logic last);
            quant_result_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result quantized=%0d", $time, value);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (value !== e.value) begin
                $display("%0t: quantized expected %0d actual %0d", $time, e.value, value);
                errors++;
            end
            if (bad !== e.bad_offset) begin
                $display("%0t: offset_invalid expected %0b actual %0b",
                         $time, e.bad_offset, bad);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_out expected %0b actual %0b", $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [31:0]        sample_bits;
    logic               last_in;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] quantized;
    logic               offset_invalid;
    logic               last_out;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    quant_scoreboard sb;
    int              cycles;
    int              sent;
    int              phases;
    int              stall_left;
    bit              steady;

    affine_quantize_float_to_int u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_bits    (sample_bits),
        .last_in        (last_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .quantized      (quantized),
        .offset_invalid (offset_invalid),
        .last_out       (last_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Accepted requests, results and register writes.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready)
                sb.note_request(sample_bits, last_in);
            if (out_valid && out_ready)
                sb.check_result(quantized, offset_invalid, last_out);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Receiver: random stall after each result unless in a steady stretch.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            out_ready <= 1'b1;
            if (out_valid && out_ready && !steady)
                stall_left <= $urandom_range(0, 4);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, sb.pending_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_sample(logic [31:0] bits, logic last);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_bits <= bits;
        last_in     <= last;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // Drain the pipe, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        in_valid <= 1'b0;
        // Let the monitor log the request accepted at this edge first.
        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_scale();
        case ($urandom_range(0, 10))
            0: return SCALE_RESET;
            1: return 32'h0000_0000;
            2: return 32'h7F80_0000;
            3: return 32'h7FC0_0000;
            4: return 32'h0000_0001;
            5: return 32'h7F7F_FFFF;
            6: return $urandom();
            // Powers of two keep halfway samples exact after scaling.
            7: return {1'($urandom_range(0, 4) == 0), 8'($urandom_range(120, 134)), 23'd0};
            default: return {1'($urandom_range(0, 4) == 0), 8'($urandom_range(110, 140)),
                             23'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return -32'sd128;
            2: return 32'd127;
            3: return 32'd255;
            4: return 32'd256;
            5: return -32'sd129;
            6: return 32'h8000_0000;
            7: return 32'h7FFF_FFFF;
            8: return $urandom();
            default: return 32'($urandom_range(0, 400)) - 32'd200;
        endcase
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [7:0]  tie_ex;
        logic [22:0] tie_frac;
        // Set the one-half bit and clear everything below it.
        tie_ex   = 8'($urandom_range(127, 148));
        tie_frac = (23'($urandom()) & ~((23'd2 << (149 - tie_ex)) - 23'd1))
                   | (23'd1 << (149 - tie_ex));
        case ($urandom_range(0, 19))
            0, 1, 2: return $urandom();
            3: return {1'($urandom()), 8'hFF, 23'($urandom_range(0, 1) ? $urandom() : 0)};
            4: return {1'($urandom()), 8'h00, 23'($urandom())};
            5: return {1'($urandom()), 8'($urandom_range(150, 170)), 23'($urandom())};
            // Exact halves to exercise ties.
            6: return {1'($urandom()), tie_ex, tie_frac};
            default: return {1'($urandom()), 8'($urandom_range(100, 160)), 23'($urandom())};
        endcase
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample_bits = '0;
        last_in     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_INV_SCALE;
        cfg_data    = '0;
        cycles      = 0;
        sent        = 0;
        phases      = 0;
        steady      = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                     32'h3F00_0000, 32'hBF00_0000, 32'h3FC0_0000, 32'h4020_0000,
                     32'h42FF_0000, 32'h4300_0000, 32'hC300_0000, 32'h7F7F_FFFF,
                     32'hFF7F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                     32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF, 32'h4F00_0000};
        foreach (directed[i])
            send_sample(directed[i], i[0]);
        // Infinity times a zero scale, then a NaN scale, with a negative offset on uint8.
        write_reg(CFG_INV_SCALE, 32'h0000_0000);
        write_reg(CFG_ZERO_OFF, -32'sd5);
        write_reg(CFG_TYPE, TYPE_UINT8);
        send_sample(32'h7F80_0000, 1'b0);
        send_sample(32'h4000_0000, 1'b1);
        write_reg(CFG_INV_SCALE, 32'h7FC0_0000);
        send_sample(32'h4000_0000, 1'b0);
        // Unused index must change nothing.
        write_reg(2'd3, 32'hFFFF_FFFF);
        send_sample(32'h4000_0000, 1'b1);

        while (sent < 1620) begin
            phases++;
            steady = ($urandom_range(0, 3) == 0);
            write_reg(CFG_INV_SCALE, pick_scale());
            write_reg(CFG_ZERO_OFF, pick_offset());
            write_reg(CFG_TYPE, 2'($urandom_range(0, 3)));
            repeat ($urandom_range(60, 140))
                send_sample(pick_sample(), 1'($urandom()));
        end
        in_valid <= 1'b0;
        steady = 1'b0;

        @(posedge clk);
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Quantized %0d samples over %0d register settings, %0d results checked.",
                 sent, phases, sb.checked);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
